// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock with an active-low reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication that must hold on every clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// implication checked on the cycle that follows the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/sdff_pkg.sv =====
// constants shared by the signed decimal field formatter and its checker
package sdff_pkg;

    localparam int ValueW  = 32;
    localparam int FieldW  = 5;
    localparam int CharW   = 8;
    localparam int BcdDigits = 10;
    localparam int BcdW    = 4 * BcdDigits;
    localparam int CntW    = 5;

    localparam logic [CharW-1:0] CharZero  = 8'd48;
    localparam logic [CharW-1:0] CharMinus = 8'd45;
    localparam logic [CharW-1:0] CharNone  = 8'd0;

    typedef logic [BcdW-1:0] t_bcd;

endpackage

// ===== rtl/core/signed_decimal_field_formatter_top.sv =====
// signed decimal field formatter: bit-serial binary to bcd, then one character per cycle
//
// A transfer is taken when start is high and busy is low. The magnitude of the value is
// converted bit-serially to ten bcd digits by shift-and-add-3, one input bit per cycle, then
// the digits leave one per cycle, lowest first, from the rightmost field position leftward,
// followed by a minus sign when the value is negative and a position is left. Each
// character shows on the outputs for exactly one cycle with o_strobe high; the receiver
// cannot stall, so it must take every strobed cycle. o_last marks the final character.
// A zero field width gives a single strobe with o_write_enable low. Widths above
// MAX_WIDTH are clipped to MAX_WIDTH. busy is high from the cycle after the transfer to
// the cycle of the last strobe inclusive.
module signed_decimal_field_formatter_top #(
    parameter int MAX_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [sdff_pkg::ValueW-1:0] i_value,
    input  logic [sdff_pkg::FieldW-1:0]      i_field_width,
    output logic                             o_strobe,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_position,
    output logic [sdff_pkg::CharW-1:0]       o_char_code,
    output logic                             o_write_enable,
    output logic                             o_last
);

    localparam int PosW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = 7;
    localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);

    // state codes
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StConv = 3'd1;
    localparam logic [2:0] StEmit = 3'd2;
    localparam logic [2:0] StSign = 3'd3;
    localparam logic [2:0] StNone = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic [sdff_pkg::CntW-1:0]      r_cnt, n_cnt;
    logic [sdff_pkg::ValueW-1:0]    r_bin, n_bin;
    sdff_pkg::t_bcd                 r_bcd, n_bcd;
    logic [PosW-1:0]                r_pos, n_pos;
    logic                           r_neg, n_neg;

    logic                           accept;
    logic [WW-1:0]                  width_ext;
    logic [WW-1:0]                  width_sat;
    logic [sdff_pkg::ValueW-1:0]    mag;
    sdff_pkg::t_bcd                 bcd_adj;
    logic                           room;      // a position remains left of the current one
    logic                           more_dig;  // higher digits still non-zero

    assign accept    = start && !busy;
    assign busy      = (r_state != StIdle);
    assign width_ext = {{(WW - sdff_pkg::FieldW){1'b0}}, i_field_width};
    assign width_sat = (width_ext > MaxW) ? MaxW : width_ext;
    // two's complement magnitude, the most negative value maps to 2^31 unsigned
    assign mag       = i_value[sdff_pkg::ValueW-1] ? (~i_value + 1'b1) : i_value;

    assign room     = (r_pos != '0);
    assign more_dig = (r_bcd[sdff_pkg::BcdW-1:4] != '0);

    // shift-and-add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < sdff_pkg::BcdDigits; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                           : r_bcd[4*i +: 4];
        end
    end

    // output decode straight from the state registers
    always_comb begin
        o_strobe       = 1'b0;
        o_position     = r_pos;
        o_char_code    = sdff_pkg::CharNone;
        o_write_enable = 1'b0;
        o_last         = 1'b0;
        case (r_state)
            StEmit: begin
                o_strobe       = 1'b1;
                o_char_code    = sdff_pkg::CharZero + {4'b0000, r_bcd[3:0]};
                o_write_enable = 1'b1;
                o_last         = !(room && (more_dig || r_neg));
            end
            StSign: begin
                o_strobe       = 1'b1;
                o_char_code    = sdff_pkg::CharMinus;
                o_write_enable = 1'b1;
                o_last         = 1'b1;
            end
            StNone: begin
                o_strobe       = 1'b1;
                o_position     = '0;
                o_last         = 1'b1;
            end
            default: ;
        endcase
    end

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_pos   = r_pos;
        n_neg   = r_neg;
        case (r_state)
            StIdle: begin
                if (accept) begin
                    n_neg = i_value[sdff_pkg::ValueW-1];
                    n_bin = mag;
                    n_bcd = '0;
                    n_cnt = '0;
                    n_pos = PosW'(width_sat - 1'b1);
                    if (width_sat == '0) begin
                        n_state = StNone;
                    end else begin
                        n_state = StConv;
                    end
                end
            end
            StConv: begin
                // one binary bit enters the bcd register per cycle, msb first
                n_bcd = {bcd_adj[sdff_pkg::BcdW-2:0], r_bin[sdff_pkg::ValueW-1]};
                n_bin = {r_bin[sdff_pkg::ValueW-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = StEmit;
                end
            end
            StEmit: begin
                n_bcd = {4'b0000, r_bcd[sdff_pkg::BcdW-1:4]};
                if (room) begin
                    n_pos = r_pos - 1'b1;
                    if (more_dig) begin
                        n_state = StEmit;
                    end else if (r_neg) begin
                        n_state = StSign;
                    end else begin
                        n_state = StIdle;
                    end
                end else begin
                    n_state = StIdle;
                end
            end
            StSign: n_state = StIdle;
            StNone: n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_pos <= n_pos;
        r_neg <= n_neg;
    end

endmodule

// ===== rtl/core/sdff_checker.sv =====
// port-level checker for the signed decimal field formatter, with its bind
`include "assert_macros.svh"

module sdff_checker #(
    parameter int MAX_WIDTH = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_strobe,
    input logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_position,
    input logic [sdff_pkg::CharW-1:0]       o_char_code,
    input logic                             o_write_enable,
    input logic                             o_last
);

    // results only appear while an item is in flight
    `ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "strobe while not busy")

    // the final character frees the block on the next cycle
    `ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_strobe && o_last, !busy, "busy after last")

    // a taken transfer makes the block busy
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")

    // a result without a write only comes alone, as the final one, at position zero
    `ASSERT_IMPL(a_nowrite_last, i_clk, i_rst_n, o_strobe && !o_write_enable,
        o_last && (o_position == '0), "no-write not last")

    // the minus sign always closes the item
    `ASSERT_IMPL(a_sign_last, i_clk, i_rst_n,
        o_strobe && o_write_enable && (o_char_code == sdff_pkg::CharMinus), o_last, "sign not last")

endmodule

bind signed_decimal_field_formatter_top sdff_checker #(.MAX_WIDTH(MAX_WIDTH)) u_sdff_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_position     (o_position),
    .o_char_code    (o_char_code),
    .o_write_enable (o_write_enable),
    .o_last         (o_last)
);

// ===== tb/tb_signed_decimal_field_formatter_top.sv =====
// self-checking testbench for the signed decimal field formatter top level
module tb_signed_decimal_field_formatter_top;
    timeunit 1ns;
    timeprecision 1ps;

    // block configuration and derived widths
    localparam int MaxWidth = 16;
    localparam int PosW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
    // generous bound on the whole run, far beyond the slowest legal run
    localparam int CycleLimit = 200000;
    // settle this long after the last character
    localparam int DrainCycles = 64;

    // one character write as seen on the result ports
    typedef struct packed {
        logic [PosW-1:0]            position;
        logic [sdff_pkg::CharW-1:0] char_code;
        logic                       write_enable;
        logic                       last;
    } t_char_write;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic signed [sdff_pkg::ValueW-1:0] i_value = '0;
    logic [sdff_pkg::FieldW-1:0]        i_field_width = '0;
    logic                               o_strobe;
    logic [PosW-1:0]                    o_position;
    logic [sdff_pkg::CharW-1:0]         o_char_code;
    logic                               o_write_enable;
    logic                               o_last;

    // character writes still owed by the block, oldest first
    t_char_write pending_writes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    // chance in a hundred that the sender holds off before an item
    int          sender_idle_pct = 0;

    signed_decimal_field_formatter_top #(
        .MAX_WIDTH(MaxWidth)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_field_width  (i_field_width),
        .o_strobe       (o_strobe),
        .o_position     (o_position),
        .o_char_code    (o_char_code),
        .o_write_enable (o_write_enable),
        .o_last         (o_last)
    );

    always #4 i_clk = ~i_clk;

    // works out the character writes for one value and field width and
    // appends them to the expected queue
    function automatic void format_field(input logic signed [sdff_pkg::ValueW-1:0] value,
                                         input logic [sdff_pkg::FieldW-1:0] field_width);
        t_char_write                 writes[$];
        t_char_write                 w;
        logic                        negative;
        logic [sdff_pkg::ValueW-1:0] magnitude;
        logic [sdff_pkg::ValueW-1:0] digit;
        int                          width;
        int                          pos;

        negative  = value[sdff_pkg::ValueW-1];
        magnitude = value;
        // two's complement negate wraps the most negative value onto its true magnitude
        if (negative)
            magnitude = '0 - magnitude;
        width     = (int'(field_width) > MaxWidth) ? MaxWidth : int'(field_width);

        if (width == 0) begin
            // nothing to write, a single marker result closes the item
            w.position     = '0;
            w.char_code    = sdff_pkg::CharNone;
            w.write_enable = 1'b0;
            w.last         = 1'b1;
            pending_writes.push_back(w);
            return;
        end

        // digits from the rightmost position leftward, stop on zero quotient or full field
        pos = width - 1;
        forever begin
            digit          = magnitude % 10;
            w.position     = PosW'(pos);
            w.char_code    = sdff_pkg::CharZero + digit[sdff_pkg::CharW-1:0];
            w.write_enable = 1'b1;
            w.last         = 1'b0;
            writes.push_back(w);
            pos--;
            if (pos < 0)
                break;
            magnitude = magnitude / 10;
            if (magnitude == 0)
                break;
        end

        // sign only when a position is left over
        if (negative && pos >= 0) begin
            w.position     = PosW'(pos);
            w.char_code    = sdff_pkg::CharMinus;
            w.write_enable = 1'b1;
            w.last         = 1'b0;
            writes.push_back(w);
        end

        writes[writes.size()-1].last = 1'b1;
        foreach (writes[i])
            pending_writes.push_back(writes[i]);
    endfunction

    // one transfer: optional idle gap, then start held until busy is low at an edge
    task automatic transfer_item(input logic signed [sdff_pkg::ValueW-1:0] value,
                                 input logic [sdff_pkg::FieldW-1:0] field_width);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_value       <= value;
        i_field_width <= field_width;
        do
            @(posedge i_clk);
        while (busy);
        // transfer taken at this edge
        format_field(value, field_width);
    endtask

    // sender holds off until the block has delivered everything owed
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_writes.size() > 0)
            @(posedge i_clk);
    endtask

    // mixes short numbers, full-range numbers and the extremes
    function automatic logic signed [sdff_pkg::ValueW-1:0] pick_value();
        logic signed [sdff_pkg::ValueW-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 9);
            1: v = $urandom_range(0, 99999);
            2: v = $urandom;
            3: case ($urandom_range(0, 3))
                   0: v = 32'sh8000_0000;
                   1: v = 32'sh7FFF_FFFF;
                   2: v = -32'sd1;
                   default: v = '0;
               endcase
            4: v = $urandom_range(0, 9999999);
            default: v = $urandom_range(1000000000, 2147483647);
        endcase
        // flip the sign half the time
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // mostly legal widths, now and then one above the limit
    function automatic logic [sdff_pkg::FieldW-1:0] pick_width();
        logic [31:0] r;
        if ($urandom_range(0, 9) == 0)
            r = $urandom_range(17, 31);
        else
            r = $urandom_range(0, 16);
        return r[sdff_pkg::FieldW-1:0];
    endfunction

    // ---------------------------------------------------------------
    // test tasks
    // ---------------------------------------------------------------

    // extremes of value and width, sign with and without room
    task automatic test_extremes();
        transfer_item(32'sd0, 5'd1);
        transfer_item(32'sd0, 5'd16);
        transfer_item(32'sh7FFF_FFFF, 5'd16);
        transfer_item(32'sh7FFF_FFFF, 5'd10);
        // too long for the field, high digits dropped
        transfer_item(32'sh7FFF_FFFF, 5'd3);
        // most negative value by its true magnitude
        transfer_item(32'sh8000_0000, 5'd16);
        transfer_item(32'sh8000_0000, 5'd11);
        transfer_item(32'sh8000_0000, 5'd10);
        transfer_item(32'sh5555_5555, 5'd16);
        transfer_item(32'shAAAA_AAAA, 5'd16);
    endtask

    // negative values with and without room for the sign, and a positive one
    task automatic test_sign_room();
        transfer_item(-32'sd1, 5'd1);
        transfer_item(-32'sd1, 5'd2);
        transfer_item(-32'sd10, 5'd2);
        transfer_item(-32'sd10, 5'd3);
        transfer_item(-32'sd5, 5'd16);
        transfer_item(32'sd9, 5'd16);
    endtask

    // zero width and widths above the limit
    task automatic test_field_widths();
        transfer_item(32'sd123, 5'd0);
        transfer_item(-32'sd7, 5'd0);
        transfer_item(32'sh8000_0000, 5'd0);
        transfer_item(-32'sd12345, 5'd17);
        transfer_item(32'sd987654321, 5'd31);
        transfer_item(32'sh8000_0000, 5'd31);
    endtask

    task automatic test_random_items(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count)
            transfer_item(pick_value(), pick_width());
    endtask

    // ---------------------------------------------------------------
    // result checker: every strobed cycle is taken at its closing edge
    // ---------------------------------------------------------------
    t_char_write expected_write;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected result pos=%0d char=%0d we=%0b last=%0b",
                         $realtime, o_position, o_char_code, o_write_enable, o_last);
                error_count++;
            end else begin
                expected_write = pending_writes.pop_front();
                if (o_position !== expected_write.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $realtime, expected_write.position, o_position);
                    error_count++;
                end
                if (o_char_code !== expected_write.char_code) begin
                    $display("%0t: char_code expected %0d actual %0d",
                             $realtime, expected_write.char_code, o_char_code);
                    error_count++;
                end
                if (o_write_enable !== expected_write.write_enable) begin
                    $display("%0t: write_enable expected %0b actual %0b",
                             $realtime, expected_write.write_enable, o_write_enable);
                    error_count++;
                end
                if (o_last !== expected_write.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $realtime, expected_write.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("** signed_decimal_field_formatter_top: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        // reset held at the start, then released once for good
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with a light sender gap
        sender_idle_pct = 6;
        test_extremes();
        test_sign_room();
        test_field_widths();

        // random part: light gaps, then heavy gaps, then back to back
        test_random_items(30, 6);
        wait_for_drain();
        test_random_items(30, 52);
        test_random_items(28, 0);

        // all owed characters in, then let the block settle
        wait_for_drain();
        repeat (DrainCycles) @(posedge i_clk);

        if (error_count == 0 && pending_writes.size() == 0)
            $display("** signed_decimal_field_formatter_top: PASSED **");
        else
            $display("** signed_decimal_field_formatter_top: FAILED **");
        $finish;
    end

endmodule
